[rtl/core/srwq_pkg.sv]
package srwq_pkg;

	typedef logic [1:0] req_t;

	localparam req_t REQ_ADD      = 2'd0;
	localparam req_t REQ_QUERY    = 2'd1;
	localparam req_t REQ_FILT_ADD = 2'd2;
	localparam req_t REQ_FILT_CLR = 2'd3;

	// command queue between front and back
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = 2;
	localparam int CQ_CW    = 3;

	// result queue
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = 3;
	localparam int OQ_CW    = 4;

	// classified command: add uses a/b as time/node, filter add uses b,
	// query uses a..d as start_time, to_time, from_node, to_node
	typedef struct packed {
		req_t        op;
		logic        empty_win;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} cmd_t;

	typedef struct packed {
		logic [31:0] rtime;
		logic [31:0] rnode;
		logic        found;
		logic        last;
	} res_t;

endpackage

[rtl/core/spike_ring_window_query_top.sv]
// channel | direction | handshake         | words
// ------- | --------- | ----------------- | -------------------------------------------
// request | in        | push / full       | req_type, spike_time, node_id, start_time,
//         |           |                   | to_time, from_node, to_node
// result  | out       | pop / empty       | out_time, out_node, found, last
//
// Spike add, filter add and filter clear are done by the back end in its idle state; a 4-deep
// command queue lets the front keep taking words while the back is busy.
// A query reads the ring one entry per cycle from a single RAM read port,
// slower if the 8-deep result queue backs up; an empty ring or window skips
// the scan and gives only the final word.
// No clearing pass after reset; the block takes words as soon as reset is released.
// A full result queue throttles the scan reads, so no match is lost.
module spike_ring_window_query_top import srwq_pkg::*; #(
	parameter int RING_DEPTH   = 64,
	parameter int FILTER_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [31:0] spike_time,
	input  logic [31:0] node_id,
	input  logic [31:0] start_time,
	input  logic [31:0] to_time,
	input  logic [31:0] from_node,
	input  logic [31:0] to_node,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] out_time,
	output logic [31:0] out_node,
	output logic        found,
	output logic        last
);

	cmd_t             cmd;
	logic             cmd_valid;
	logic             cmd_pop;
	logic [OQ_CW-1:0] res_count;
	logic             res_push;
	res_t             res_in;
	res_t             res_out;

	srwq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.spike_time(spike_time),
		.node_id   (node_id),
		.start_time(start_time),
		.to_time   (to_time),
		.from_node (from_node),
		.to_node   (to_node),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	srwq_back #(
		.RING_DEPTH  (RING_DEPTH),
		.FILTER_DEPTH(FILTER_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.res_count(res_count),
		.res_push (res_push),
		.res      (res_in)
	);

	srwq_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_count(res_count),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	assign out_time = res_out.rtime;
	assign out_node = res_out.rnode;
	assign found    = res_out.found;
	assign last     = res_out.last;

endmodule

[rtl/core/srwq_ram.sv]
module srwq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/srwq_front.sv]
module srwq_front import srwq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [31:0] spike_time,
	input  logic [31:0] node_id,
	input  logic [31:0] start_time,
	input  logic [31:0] to_time,
	input  logic [31:0] from_node,
	input  logic [31:0] to_node,
	output cmd_t        cmd,
	output logic        cmd_valid,
	input  logic        cmd_pop
);

	cmd_t             cmd_in;
	cmd_t             cq_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_CW-1:0] cnt_q;
	logic             wr;
	logic             rd;

	always_comb begin
		cmd_in           = '0;
		cmd_in.op        = req_type;
		case (req_type)
			REQ_ADD: begin
				cmd_in.a = spike_time;
				cmd_in.b = node_id;
			end
			REQ_QUERY: begin
				cmd_in.a = start_time;
				cmd_in.b = to_time;
				cmd_in.c = from_node;
				cmd_in.d = to_node;
				// window that can hold nothing: back skips the scan
				cmd_in.empty_win = (start_time >= to_time) || (from_node > to_node);
			end
			REQ_FILT_ADD: begin
				cmd_in.b = node_id;
			end
			default: begin
				cmd_in.b = '0;
			end
		endcase
	end

	assign full      = (cnt_q == CQ_CW'(CQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cq_q[rd_ptr_q];
	assign wr        = push && !full;
	assign rd        = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			cq_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + CQ_AW'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + CQ_AW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CQ_CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CQ_CW'(1);
			end
		end
	end

endmodule

[rtl/core/srwq_outq.sv]
module srwq_outq import srwq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	input  res_t             res_in,
	output logic [OQ_CW-1:0] res_count,
	output logic             empty,
	input  logic             pop,
	output res_t             res_out
);

	res_t             oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             rd;

	assign empty     = (cnt_q == '0);
	assign res_count = cnt_q;
	assign res_out   = oq_q[rd_ptr_q];
	assign rd        = pop && !empty;

	always_ff @(posedge clk) begin
		if (res_push) begin
			oq_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			end
			if (res_push && !rd) begin
				cnt_q <= cnt_q + OQ_CW'(1);
			end else if (rd && !res_push) begin
				cnt_q <= cnt_q - OQ_CW'(1);
			end
		end
	end

endmodule

[rtl/core/srwq_back.sv]
module srwq_back import srwq_pkg::*; #(
	parameter int RING_DEPTH   = 64,
	parameter int FILTER_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  logic [OQ_CW-1:0] res_count,
	output logic             res_push,
	output res_t             res
);

	localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int RING_CW = $clog2(RING_DEPTH + 1);
	localparam int FILT_AW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
	localparam int FILT_CW = $clog2(FILTER_DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FINAL = 2'd3;

	logic [1:0]         state_q;
	logic [RING_CW-1:0] fill_q;
	logic [RING_AW-1:0] oldest_q;
	logic [FILT_CW-1:0] fcount_q;
	logic [31:0]        fids_q [FILTER_DEPTH];
	logic [RING_AW-1:0] scan_slot_q;
	logic [RING_CW-1:0] scan_left_q;
	logic [31:0]        tlo_q, thi_q, nlo_q, nhi_q;
	logic               v_s1, v_s2;
	logic [31:0]        time_s2, node_s2;
	logic               inwin_s2, fhit_s2;
	logic               held_v_q;
	logic [31:0]        held_time_q, held_node_q;

	logic               ring_full;
	logic [RING_CW:0]   slot_sum;
	logic [RING_AW-1:0] add_slot;
	logic [RING_AW-1:0] next_scan_slot;
	logic               ram_we;
	logic [RING_AW-1:0] ram_waddr;
	logic [63:0]        rdata;
	logic [31:0]        rd_time, rd_node;
	logic [OQ_CW:0]     credit_sum;
	logic               issue;
	logic [FILTER_DEPTH-1:0] fmatch;
	logic               inwin;
	logic               hit;

	assign ring_full = (fill_q == RING_CW'(RING_DEPTH));
	assign slot_sum  = (RING_CW + 1)'(oldest_q) + (RING_CW + 1)'(fill_q);
	assign add_slot  = (slot_sum >= (RING_CW + 1)'(RING_DEPTH)) ?
		RING_AW'(slot_sum - (RING_CW + 1)'(RING_DEPTH)) : RING_AW'(slot_sum);
	assign next_scan_slot = (scan_slot_q == RING_AW'(RING_DEPTH - 1)) ?
		'0 : scan_slot_q + RING_AW'(1);

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign ram_we    = cmd_pop && (cmd.op == REQ_ADD);
	assign ram_waddr = ring_full ? oldest_q : add_slot;

	// each read in flight may push one word; never issue past the free space
	assign credit_sum = {1'b0, res_count} + (OQ_CW + 1)'(v_s1) + (OQ_CW + 1)'(v_s2);
	assign issue = (state_q == ST_SCAN) && (scan_left_q != '0) &&
		(credit_sum < (OQ_CW + 1)'(OQ_DEPTH));

	srwq_ram #(
		.WIDTH(64),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({cmd.a, cmd.b}),
		.re   (issue),
		.raddr(scan_slot_q),
		.rdata(rdata)
	);

	assign rd_time = rdata[63:32];
	assign rd_node = rdata[31:0];

	always_comb begin
		inwin = (rd_time >= tlo_q) && (rd_time < thi_q) &&
			(rd_node >= nlo_q) && (rd_node <= nhi_q);
		for (int k = 0; k < FILTER_DEPTH; k++) begin
			fmatch[k] = (fids_q[k] == rd_node) && (FILT_CW'(k) < fcount_q);
		end
	end

	assign hit = v_s2 && inwin_s2 && fhit_s2;

	always_comb begin
		res_push = 1'b0;
		res      = '0;
		case (state_q)
			ST_SCAN, ST_DRAIN: begin
				// a new match displaces the held one, which is then not last
				res_push  = hit && held_v_q;
				res.rtime = held_time_q;
				res.rnode = held_node_q;
				res.found = 1'b1;
			end
			ST_FINAL: begin
				res_push  = (res_count < OQ_CW'(OQ_DEPTH));
				res.rtime = held_v_q ? held_time_q : '0;
				res.rnode = held_v_q ? held_node_q : '0;
				res.found = held_v_q;
				res.last  = 1'b1;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.op == REQ_QUERY)) begin
			tlo_q <= cmd.a;
			thi_q <= cmd.b;
			nlo_q <= cmd.c;
			nhi_q <= cmd.d;
		end
		if (cmd_pop && (cmd.op == REQ_FILT_ADD) && (fcount_q < FILT_CW'(FILTER_DEPTH))) begin
			fids_q[fcount_q[FILT_AW-1:0]] <= cmd.b;
		end
		time_s2  <= rd_time;
		node_s2  <= rd_node;
		inwin_s2 <= inwin;
		fhit_s2  <= (fcount_q == '0) || (|fmatch);
		if (hit) begin
			held_time_q <= time_s2;
			held_node_q <= node_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			oldest_q    <= '0;
			fcount_q    <= '0;
			scan_slot_q <= '0;
			scan_left_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			held_v_q    <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (hit) begin
				held_v_q <= 1'b1;
			end
			if (issue) begin
				scan_slot_q <= next_scan_slot;
				scan_left_q <= scan_left_q - RING_CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.op)
							REQ_ADD: begin
								if (ring_full) begin
									oldest_q <= (oldest_q == RING_AW'(RING_DEPTH - 1)) ?
										'0 : oldest_q + RING_AW'(1);
								end else begin
									fill_q <= fill_q + RING_CW'(1);
								end
							end
							REQ_QUERY: begin
								held_v_q    <= 1'b0;
								scan_slot_q <= oldest_q;
								scan_left_q <= fill_q;
								state_q     <= (cmd.empty_win || (fill_q == '0)) ?
									ST_FINAL : ST_SCAN;
							end
							REQ_FILT_ADD: begin
								if (fcount_q < FILT_CW'(FILTER_DEPTH)) begin
									fcount_q <= fcount_q + FILT_CW'(1);
								end
							end
							default: begin
								fcount_q <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue && (scan_left_q == RING_CW'(1))) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (res_push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= RING_CW'(RING_DEPTH))
		else $error("ring fill count beyond depth");

	a_oldest_full: assert property (@(posedge clk) disable iff (!arst_n)
		(oldest_q != '0) |-> ring_full)
		else $error("oldest slot moved before ring filled");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_count < OQ_CW'(OQ_DEPTH)))
		else $error("result word pushed into full queue");

	a_last_once: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.last) |=> (state_q == ST_IDLE))
		else $error("query did not end after its last word");

	a_no_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ((state_q == ST_SCAN) || (state_q == ST_DRAIN)))
		else $error("scan read outstanding outside a query");

endmodule

[tb/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import srwq_pkg::*;

	localparam int RING_N = 64;
	localparam int FILT_N = 16;
	localparam int MAX_HITS = 64;
	localparam int RANDOM_WORDS = 292;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [31:0] TOP = 32'hFFFF_FFFF;

	typedef struct {
		req_t        op;
		logic [31:0] st, nid, ft, tt, fn, tn;
	} req_word_t;

	// directed row: typed rows carry their expected single result word
	typedef struct {
		req_t        op;
		logic [31:0] st, nid, ft, tt, fn, tn;
		bit          typed;
		logic [31:0] wt, wn;
		logic        wf, wl;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [1:0]  req_type = REQ_ADD;
	logic [31:0] spike_time = '0;
	logic [31:0] node_id = '0;
	logic [31:0] start_time = '0;
	logic [31:0] to_time = '0;
	logic [31:0] from_node = '0;
	logic [31:0] to_node = '0;
	logic        full, empty, found, last;
	logic [31:0] out_time, out_node;

	spike_ring_window_query_top #(
		.RING_DEPTH(RING_N),
		.FILTER_DEPTH(FILT_N)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.spike_time(spike_time),
		.node_id(node_id),
		.start_time(start_time),
		.to_time(to_time),
		.from_node(from_node),
		.to_node(to_node),
		.empty(empty),
		.pop(pop),
		.out_time(out_time),
		.out_node(out_node),
		.found(found),
		.last(last)
	);

	always #10 clk = ~clk;

	// mirror of the spike ring and filter list
	logic [31:0] ring_time [RING_N];
	logic [31:0] ring_node [RING_N];
	int unsigned ring_fill = 0;
	int unsigned ring_oldest = 0;
	logic [31:0] filt_ids [FILT_N];
	int unsigned filt_cnt = 0;

	res_t pending_hits[$];

	int fails = 0;
	int cycles = 0;
	int send_gap_pct = 0;
	int rcv_stall_pct = 0;
	int cnt_op [4] = '{0, 0, 0, 0};
	int n_results = 0;
	int n_found = 0;
	int overwrites = 0;
	int filt_drops = 0;
	logic [31:0] tick_now = '0;

	row_t plan [18] = '{
		'{REQ_QUERY,    0,   0,   0,   TOP, 0,   TOP, 1, 0,   0, 0, 1},
		'{REQ_ADD,      0,   0,   0,   0,   0,   0,   0, 0,   0, 0, 0},
		'{REQ_ADD,      TOP, TOP, TOP, TOP, TOP, TOP, 0, 0,   0, 0, 0},
		'{REQ_ADD,      100, 5,   0,   0,   0,   0,   0, 0,   0, 0, 0},
		'{REQ_ADD,      200, 7,   0,   0,   0,   0,   0, 0,   0, 0, 0},
		'{REQ_QUERY,    0,   0,   0,   TOP, 0,   TOP, 0, 0,   0, 0, 0},
		'{REQ_QUERY,    0,   0,   100, 100, 0,   TOP, 1, 0,   0, 0, 1},
		'{REQ_QUERY,    0,   0,   0,   TOP, 6,   5,   1, 0,   0, 0, 1},
		'{REQ_QUERY,    0,   0,   100, 101, 5,   5,   1, 100, 5, 1, 1},
		'{REQ_QUERY,    0,   0,   1,   100, 0,   TOP, 1, 0,   0, 0, 1},
		'{REQ_FILT_ADD, 0,   7,   0,   0,   0,   0,   0, 0,   0, 0, 0},
		'{REQ_FILT_ADD, 0,   7,   0,   0,   0,   0,   0, 0,   0, 0, 0},
		'{REQ_QUERY,    0,   0,   0,   TOP, 0,   TOP, 1, 200, 7, 1, 1},
		'{REQ_FILT_ADD, 0,   TOP, 0,   0,   0,   0,   0, 0,   0, 0, 0},
		'{REQ_QUERY,    0,   0,   0,   TOP, 0,   TOP, 0, 0,   0, 0, 0},
		'{REQ_FILT_CLR, TOP, TOP, TOP, TOP, TOP, TOP, 0, 0,   0, 0, 0},
		'{REQ_QUERY,    0,   0,   0,   TOP, TOP, TOP, 1, 0,   0, 0, 1},
		'{REQ_QUERY,    0,   0,   0,   TOP, 0,   TOP, 0, 0,   0, 0, 0}
	};

	// updates the mirror; for a query, queues the hits unless keep is low
	function automatic void predict_hits(req_word_t w, bit keep);
		res_t        hits[$];
		res_t        one;
		int unsigned slot;
		logic [31:0] t, n;
		bit          listed;
		case (w.op)
			REQ_ADD: begin
				if (ring_fill < RING_N) begin
					slot = (ring_oldest + ring_fill) % RING_N;
					ring_fill++;
				end else begin
					slot = ring_oldest;
					ring_oldest = (ring_oldest + 1) % RING_N;
					overwrites++;
				end
				ring_time[slot] = w.st;
				ring_node[slot] = w.nid;
			end
			REQ_FILT_ADD: begin
				if (filt_cnt < FILT_N) begin
					filt_ids[filt_cnt] = w.nid;
					filt_cnt++;
				end else
					filt_drops++;
			end
			REQ_FILT_CLR: filt_cnt = 0;
			default: begin
				for (int k = 0; k < ring_fill; k++) begin
					slot = (ring_oldest + k) % RING_N;
					t = ring_time[slot];
					n = ring_node[slot];
					listed = (filt_cnt == 0);
					for (int j = 0; j < filt_cnt; j++)
						if (filt_ids[j] == n)
							listed = 1'b1;
					if (t >= w.ft && t < w.tt && n >= w.fn && n <= w.tn && listed &&
					    hits.size() < MAX_HITS) begin
						one = '{t, n, 1'b1, 1'b0};
						hits.insert(hits.size(), one);
					end
				end
				if (hits.size() == 0) begin
					one = '{32'd0, 32'd0, 1'b0, 1'b1};
					hits.insert(0, one);
				end else
					hits[hits.size() - 1].last = 1'b1;
				if (keep)
					foreach (hits[i])
						pending_hits.insert(pending_hits.size(), hits[i]);
			end
		endcase
	endfunction

	task automatic send_word(req_word_t w, bit keep);
		while ($urandom_range(99) < send_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req_type <= w.op;
		spike_time <= w.st;
		node_id <= w.nid;
		start_time <= w.ft;
		to_time <= w.tt;
		from_node <= w.fn;
		to_node <= w.tn;
		@(posedge clk);
		while (full)
			@(posedge clk);
		cnt_op[w.op]++;
		predict_hits(w, keep);
	endtask

	// unused fields get random bits; the block must ignore them
	function automatic req_word_t rand_word(req_t op);
		req_word_t w;
		w = '{op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return w;
	endfunction

	function automatic logic [31:0] pick_node();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 6)
			return $urandom_range(15);
		else if (r < 8)
			return TOP - $urandom_range(3);
		else
			return $urandom;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// result side
	initial begin
		res_t want;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_hits.size() == 0) begin
					$error("unexpected result word: time %h node %h found %b last %b",
					       out_time, out_node, found, last);
					fails++;
				end else begin
					want = pending_hits.pop_front();
					n_results++;
					if (found)
						n_found++;
					if (out_time !== want.rtime) begin
						$error("out_time: expected %h, got %h", want.rtime, out_time);
						fails++;
					end
					if (out_node !== want.rnode) begin
						$error("out_node: expected %h, got %h", want.rnode, out_node);
						fails++;
					end
					if (found !== want.found) begin
						$error("found: expected %b, got %b", want.found, found);
						fails++;
					end
					if (last !== want.last) begin
						$error("last: expected %b, got %b", want.last, last);
						fails++;
					end
				end
			end
			pop <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	initial begin
		req_word_t   w;
		res_t        typed_res;
		int          sent;
		int          burst;
		int          total;
		int unsigned r, back;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			w = '{plan[i].op, plan[i].st, plan[i].nid, plan[i].ft, plan[i].tt,
			      plan[i].fn, plan[i].tn};
			send_word(w, !plan[i].typed);
			if (plan[i].typed) begin
				typed_res = '{plan[i].wt, plan[i].wn, plan[i].wf, plan[i].wl};
				pending_hits.insert(pending_hits.size(), typed_res);
			end
		end

		// phases: free running, sender gaps, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			send_gap_pct = (phase == 1) ? 82 : (phase == 3) ? 33 : 0;
			rcv_stall_pct = (phase == 2) ? 82 : (phase == 3) ? 33 : 0;
			while (sent < (phase + 1) * RANDOM_WORDS / 4) begin
				r = $urandom_range(99);
				if (r < 50) begin
					burst = $urandom_range(1, 10);
					repeat (burst) begin
						w = rand_word(REQ_ADD);
						tick_now += $urandom_range(25);
						case ($urandom_range(19))
							0: w.st = 32'd0;
							1: w.st = TOP;
							2: ;
							default: w.st = tick_now;
						endcase
						w.nid = pick_node();
						send_word(w, 1'b1);
						sent++;
					end
				end else if (r < 62) begin
					if ($urandom_range(1)) begin
						send_word(rand_word(REQ_FILT_CLR), 1'b1);
						sent++;
					end
					burst = $urandom_range(1, 20);
					repeat (burst) begin
						w = rand_word(REQ_FILT_ADD);
						w.nid = pick_node();
						send_word(w, 1'b1);
						sent++;
					end
				end else if (r < 67) begin
					send_word(rand_word(REQ_FILT_CLR), 1'b1);
					sent++;
				end else begin
					burst = $urandom_range(1, 2);
					repeat (burst) begin
						w = rand_word(REQ_QUERY);
						case ($urandom_range(9))
							0, 1: begin
								w.ft = 0;
								w.tt = TOP;
								w.fn = 0;
								w.tn = TOP;
							end
							2, 3, 4: begin
								back = $urandom_range(400);
								w.ft = (tick_now > back) ? tick_now - back : 32'd0;
								w.tt = w.ft + $urandom_range(1, 500);
								if ($urandom_range(1)) begin
									w.fn = $urandom_range(15);
									w.tn = w.fn + $urandom_range(15);
								end else begin
									w.fn = 0;
									w.tn = TOP;
								end
							end
							5: begin
								w.ft = 0;
								w.tt = TOP;
								w.fn = pick_node();
								w.tn = w.fn;
							end
							6: ;
							7: begin
								// inverted or zero-width time window
								if (w.tt > w.ft)
									{w.ft, w.tt} = {w.tt, w.ft};
							end
							8: begin
								w.fn = $urandom | 32'd1;
								w.tn = w.fn - 32'd1;
							end
							default: begin
								w.ft = tick_now;
								w.tt = tick_now;
							end
						endcase
						send_word(w, 1'b1);
						sent++;
					end
				end
			end
		end
		push <= 1'b0;

		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		total = cnt_op[REQ_ADD] + cnt_op[REQ_QUERY] + cnt_op[REQ_FILT_ADD] +
		        cnt_op[REQ_FILT_CLR];
		$write("%0d requests: %0d adds, %0d queries, %0d filter adds, %0d clears; ",
		       total, cnt_op[REQ_ADD], cnt_op[REQ_QUERY], cnt_op[REQ_FILT_ADD],
		       cnt_op[REQ_FILT_CLR]);
		$display("%0d ring overwrites, %0d filter adds dropped", overwrites, filt_drops);
		$display("%0d result words checked, %0d carrying a spike, %0d mismatches",
		         n_results, n_found, fails);
		if (fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

[sim.f]
rtl/core/srwq_pkg.sv
rtl/core/srwq_ram.sv
rtl/core/srwq_front.sv
rtl/core/srwq_outq.sv
rtl/core/srwq_back.sv
rtl/core/spike_ring_window_query_top.sv
tb/tb.sv
